### hw/rtl/tcch_pkg.sv
// package with step codes, control word layout and microcode rom of the console front end
`default_nettype none

package tcch_pkg;

  // field and register widths
  localparam int CURSOR_W  = 9;
  localparam int DIM_W     = 10;
  localparam int CHAR_W    = 8;
  localparam int NUM_W     = 64;
  localparam int NIB_W     = 4;
  localparam int NIB_COUNT = NUM_W / NIB_W;
  localparam int REM_W     = $clog2(NIB_COUNT + 1);
  localparam int CFG_IDX_W = 1;

  // screen size limits
  localparam int MAX_DIM      = 512;
  localparam int CURSOR_REACH = 1 << CURSOR_W;
  localparam int DIM_LIMIT    = (MAX_DIM < CURSOR_REACH) ? MAX_DIM : CURSOR_REACH;

  localparam logic [DIM_W-1:0] COLUMNS_RESET = DIM_W'(80);
  localparam logic [DIM_W-1:0] ROWS_RESET    = DIM_W'(25);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = CFG_IDX_W'(1);

  // special character codes
  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

  // func codes
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_HEX  = 1'b1;

  // microcode step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_WAIT    = 3'd0;
  localparam step_t STEP_NEWLINE = 3'd1;
  localparam step_t STEP_CHAR    = 3'd2;
  localparam step_t STEP_ZERO    = 3'd3;
  localparam step_t STEP_X       = 3'd4;
  localparam step_t STEP_SKIP    = 3'd5;
  localparam step_t STEP_DIGIT   = 3'd6;

  typedef enum logic [2:0] {
    GLYPH_NONE,
    GLYPH_CHAR,
    GLYPH_ZERO,
    GLYPH_X,
    GLYPH_DIGIT
  } glyph_sel_t;

  typedef enum logic [1:0] {
    NIB_HOLD,
    NIB_SKIP,
    NIB_EMIT
  } nib_op_t;

  typedef enum logic [1:0] {
    LAST_NEVER,
    LAST_ALWAYS,
    LAST_ON_FINAL
  } last_sel_t;

  // a step moves on to its target when its condition holds, else it repeats
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_DISPATCH,
    COND_SKIP_DONE,
    COND_FINAL_DIGIT
  } cond_t;

  typedef struct packed {
    glyph_sel_t glyph_sel;
    logic       newline;
    nib_op_t    nib_op;
    last_sel_t  last_sel;
    cond_t      cond;
    step_t      target;
  } ctl_t;

  // control store
  function automatic ctl_t ucode_rom(input step_t s);
    ctl_t w;
    w = '{GLYPH_NONE, 1'b0, NIB_HOLD, LAST_NEVER, COND_DISPATCH, STEP_WAIT};
    unique case (s)
      STEP_WAIT:    w = '{GLYPH_NONE,  1'b0, NIB_HOLD, LAST_NEVER,    COND_DISPATCH,
                          STEP_WAIT};
      STEP_NEWLINE: w = '{GLYPH_NONE,  1'b1, NIB_HOLD, LAST_NEVER,    COND_ALWAYS,
                          STEP_WAIT};
      STEP_CHAR:    w = '{GLYPH_CHAR,  1'b0, NIB_HOLD, LAST_ALWAYS,   COND_ALWAYS,
                          STEP_WAIT};
      STEP_ZERO:    w = '{GLYPH_ZERO,  1'b0, NIB_HOLD, LAST_NEVER,    COND_ALWAYS,
                          STEP_X};
      STEP_X:       w = '{GLYPH_X,     1'b0, NIB_HOLD, LAST_NEVER,    COND_ALWAYS,
                          STEP_SKIP};
      STEP_SKIP:    w = '{GLYPH_NONE,  1'b0, NIB_SKIP, LAST_NEVER,    COND_SKIP_DONE,
                          STEP_DIGIT};
      STEP_DIGIT:   w = '{GLYPH_DIGIT, 1'b0, NIB_EMIT, LAST_ON_FINAL, COND_FINAL_DIGIT,
                          STEP_WAIT};
      default:      w = '{GLYPH_NONE,  1'b0, NIB_HOLD, LAST_NEVER,    COND_ALWAYS,
                          STEP_WAIT};
    endcase
    return w;
  endfunction

  // upper-case hex digit glyph
  function automatic logic [CHAR_W-1:0] hex_glyph(input logic [NIB_W-1:0] nib);
    logic [CHAR_W-1:0] wide;
    wide = {{(CHAR_W-NIB_W){1'b0}}, nib};
    if (nib < NIB_W'(10)) begin
      return CHAR_ZERO + wide;
    end
    return CHAR_UPPER_A + wide - CHAR_W'(10);
  endfunction

  // screen size as used: zero acts as one, large values clip to the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (v > DIM_W'(DIM_LIMIT)) begin
      return DIM_W'(DIM_LIMIT);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/text_console_cursor_hex_top.sv
// Text console front end: cursor tracking and glyph command generation.
// A microcoded sequencer runs one control word per cycle unless stalled; its step counter sets the timing.
// The first glyph of an accepted item goes through the step register, then the output register.
// One item is in work at a time; the next is taken once the sequencer is back at its wait step.
// Reset (synchronous, active high): cursor at 0,0, 80 columns, 25 rows, output empty.
`default_nettype none

module text_console_cursor_hex_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [tcch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcch_pkg::DIM_W-1:0]      cfg_data,
  // input items
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            func,
  input  wire logic [tcch_pkg::CHAR_W-1:0]     character,
  input  wire logic [tcch_pkg::NUM_W-1:0]      number,
  // glyph commands
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tcch_pkg::CURSOR_W-1:0]        glyph_column,
  output logic [tcch_pkg::CURSOR_W-1:0]        glyph_row,
  output logic [tcch_pkg::CHAR_W-1:0]          glyph,
  output logic                                 last
);
  import tcch_pkg::*;

  logic [DIM_W-1:0]    columns;
  logic [DIM_W-1:0]    rows;
  logic [CURSOR_W-1:0] cursor_column;
  logic [CURSOR_W-1:0] cursor_row;
  step_t               pc;
  step_t               pc_next;
  logic [CHAR_W-1:0]   char_reg;
  logic [NUM_W-1:0]    num_reg;
  logic [REM_W-1:0]    rem;

  ctl_t                ctl;
  logic                slot_free;
  logic                emits;
  logic                fire;
  logic                cond_true;
  logic                final_nib;
  logic                top_zero;
  step_t               dispatch_target;
  logic [CHAR_W-1:0]   glyph_val;
  logic                last_val;
  logic [DIM_W-1:0]    eff_cols;
  logic [DIM_W-1:0]    eff_rows;
  logic [DIM_W-1:0]    col_inc;
  logic [DIM_W-1:0]    row_inc;
  logic [CURSOR_W-1:0] nl_row;
  logic [CURSOR_W-1:0] adv_col;
  logic [CURSOR_W-1:0] adv_row;
  logic                do_shift;

  // control word fetch and step firing
  assign ctl       = ucode_rom(pc);
  assign emits     = (ctl.glyph_sel != GLYPH_NONE);
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (pc == STEP_WAIT);
  assign fire      = (pc == STEP_WAIT) ? in_valid : (!emits || slot_free);

  assign final_nib = (rem == REM_W'(1));
  assign top_zero  = (num_reg[NUM_W-1 -: NIB_W] == '0);

  // dispatch on the incoming transaction
  always_comb begin
    if (func == FUNC_HEX) begin
      dispatch_target = STEP_ZERO;
    end else if (character == CHAR_NEWLINE) begin
      dispatch_target = STEP_NEWLINE;
    end else if (character == CHAR_NUL) begin
      dispatch_target = STEP_WAIT;
    end else begin
      dispatch_target = STEP_CHAR;
    end
  end

  // jump condition
  always_comb begin
    unique case (ctl.cond)
      COND_ALWAYS:      cond_true = 1'b1;
      COND_DISPATCH:    cond_true = 1'b1;
      COND_SKIP_DONE:   cond_true = !top_zero || final_nib;
      COND_FINAL_DIGIT: cond_true = final_nib;
      default:          cond_true = 1'b1;
    endcase
  end

  always_comb begin
    pc_next = pc;
    if (fire && cond_true) begin
      pc_next = (ctl.cond == COND_DISPATCH) ? dispatch_target : ctl.target;
    end
  end

  // glyph and last flag selection
  always_comb begin
    unique case (ctl.glyph_sel)
      GLYPH_NONE:  glyph_val = CHAR_NUL;
      GLYPH_CHAR:  glyph_val = char_reg;
      GLYPH_ZERO:  glyph_val = CHAR_ZERO;
      GLYPH_X:     glyph_val = CHAR_X;
      GLYPH_DIGIT: glyph_val = hex_glyph(num_reg[NUM_W-1 -: NIB_W]);
      default:     glyph_val = CHAR_NUL;
    endcase
    unique case (ctl.last_sel)
      LAST_NEVER:    last_val = 1'b0;
      LAST_ALWAYS:   last_val = 1'b1;
      LAST_ON_FINAL: last_val = final_nib;
      default:       last_val = 1'b0;
    endcase
  end

  // cursor advance and newline
  assign eff_cols = eff_dim(columns);
  assign eff_rows = eff_dim(rows);
  assign col_inc  = {1'b0, cursor_column} + DIM_W'(1);
  assign row_inc  = {1'b0, cursor_row} + DIM_W'(1);
  assign nl_row   = (row_inc < eff_rows) ? row_inc[CURSOR_W-1:0] : '0;

  always_comb begin
    if (col_inc < eff_cols) begin
      adv_col = col_inc[CURSOR_W-1:0];
      adv_row = cursor_row;
    end else begin
      adv_col = '0;
      adv_row = nl_row;
    end
  end

  // nibble shifter: skip leading zeros, or step past an emitted digit
  always_comb begin
    unique case (ctl.nib_op)
      NIB_HOLD: do_shift = 1'b0;
      NIB_SKIP: do_shift = fire && !cond_true;
      NIB_EMIT: do_shift = fire;
      default:  do_shift = 1'b0;
    endcase
  end

  // sequencer, cursor and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= STEP_WAIT;
      cursor_column <= '0;
      cursor_row    <= '0;
      columns       <= COLUMNS_RESET;
      rows          <= ROWS_RESET;
    end else begin
      pc <= pc_next;
      if (fire && emits) begin
        cursor_column <= adv_col;
        cursor_row    <= adv_row;
      end else if (fire && ctl.newline) begin
        cursor_column <= '0;
        cursor_row    <= nl_row;
      end
      if (cfg_we) begin
        if (cfg_index == REG_COLUMNS) begin
          columns <= cfg_data;
        end else if (cfg_index == REG_ROWS) begin
          rows <= cfg_data;
        end
      end
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (pc == STEP_WAIT && in_valid) begin
      char_reg <= character;
      num_reg  <= number;
      rem      <= REM_W'(NIB_COUNT);
    end else if (do_shift) begin
      num_reg <= {num_reg[NUM_W-NIB_W-1:0], {NIB_W{1'b0}}};
      rem     <= rem - REM_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emits) begin
      glyph_column <= cursor_column;
      glyph_row    <= cursor_row;
      glyph        <= glyph_val;
      last         <= last_val;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_SKIP || pc == STEP_DIGIT) |-> (rem != '0))
    else $error("nibble count empty during hex print");

  assert property (@(posedge clk) disable iff (rst)
    (fire && emits && last_val) |=> in_ready)
    else $error("sequencer not back at wait after final glyph");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == FUNC_HEX) |=> (pc == STEP_ZERO))
    else $error("hex transaction not dispatched to prefix");

  assert property (@(posedge clk) disable iff (rst)
    (fire && emits && !slot_free) |-> 1'b0)
    else $error("glyph issued over an occupied output register");

endmodule

`default_nettype wire

### test/text_console_cursor_hex_top_test.sv
// self-checking testbench for the text console cursor and hex front end
`timescale 1ns / 1ps

module text_console_cursor_hex_top_test;
  import tcch_pkg::*;

  localparam int SCREEN_CAP  = DIM_LIMIT;
  localparam int RUN_LIMIT   = 1_000_000;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 250;

  typedef struct {
    logic              func_code;
    logic [CHAR_W-1:0] ch;
    logic [NUM_W-1:0]  num;
  } item_t;

  typedef struct {
    logic [CURSOR_W-1:0] column;
    logic [CURSOR_W-1:0] row;
    logic [CHAR_W-1:0]   glyph;
    logic                last;
  } glyph_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COLUMNS;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 func = FUNC_CHAR;
  logic [CHAR_W-1:0]    character = '0;
  logic [NUM_W-1:0]     number = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CURSOR_W-1:0]  glyph_column;
  logic [CURSOR_W-1:0]  glyph_row;
  logic [CHAR_W-1:0]    glyph;
  logic                 last;

  text_console_cursor_hex_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .character    (character),
    .number       (number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .glyph_column (glyph_column),
    .glyph_row    (glyph_row),
    .glyph        (glyph),
    .last         (last)
  );

  always #5 clk = ~clk;

  // screen model and expected glyph commands
  logic [DIM_W-1:0]    columns_set = COLUMNS_RESET;
  logic [DIM_W-1:0]    rows_set = ROWS_RESET;
  logic [CURSOR_W-1:0] cur_col = '0;
  logic [CURSOR_W-1:0] cur_row = '0;
  glyph_cmd_t          glyph_queue[$];
  item_t               pending[$];

  int  errors = 0;
  int  checked = 0;
  int  accepted_items = 0;
  int  n_hex = 0;
  int  n_print = 0;
  int  n_quiet = 0;
  int  settings = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;
  logic calm = 1'b0;

  // screen size as the cursor sees it
  function automatic int usable(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > SCREEN_CAP) return SCREEN_CAP;
    return int'(v);
  endfunction

  task automatic next_line();
    cur_col = '0;
    if (int'(cur_row) + 1 < usable(rows_set)) cur_row = cur_row + CURSOR_W'(1);
    else cur_row = '0;
  endtask

  task automatic draw(input logic [CHAR_W-1:0] g);
    glyph_queue.push_back('{cur_col, cur_row, g, 1'b0});
    if (int'(cur_col) + 1 < usable(columns_set)) cur_col = cur_col + CURSOR_W'(1);
    else next_line();
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] nib);
    if (nib < NIB_W'(10)) return CHAR_ZERO + CHAR_W'(nib);
    return CHAR_UPPER_A + CHAR_W'(nib) - CHAR_W'(10);
  endfunction

  // expected glyph commands for one item, last flag on the final one
  task automatic print_item(input item_t it);
    int before_n;
    int digits;
    before_n = glyph_queue.size();
    if (it.func_code == FUNC_HEX) begin
      draw(CHAR_ZERO);
      draw(CHAR_X);
      if (it.num == '0) begin
        draw(CHAR_ZERO);
      end else begin
        digits = 0;
        while (digits < NIB_COUNT && (it.num >> (NIB_W * digits)) != '0) digits++;
        for (int d = digits - 1; d >= 0; d--) draw(digit_char(it.num[NIB_W*d +: NIB_W]));
      end
    end else if (it.ch == CHAR_NEWLINE) begin
      next_line();
    end else if (it.ch != CHAR_NUL) begin
      draw(it.ch);
    end
    if (glyph_queue.size() > before_n) glyph_queue[glyph_queue.size()-1].last = 1'b1;
  endtask

  // idle length: none while calm, else mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [NUM_W-1:0] rand_number();
    logic [NUM_W-1:0] v;
    int nibs;
    v = {$urandom, $urandom};
    nibs = ($urandom_range(0, 1) == 0) ? NIB_COUNT : $urandom_range(0, NIB_COUNT);
    if (nibs == 0) return '0;
    return v >> (NUM_W - NIB_W * nibs);
  endfunction

  function automatic item_t rand_item(input int hex_pct);
    item_t it;
    int pick;
    it.num = rand_number();
    it.ch = CHAR_W'($urandom_range(0, 255));
    it.func_code = ($urandom_range(0, 99) < hex_pct) ? FUNC_HEX : FUNC_CHAR;
    pick = $urandom_range(0, 99);
    if (it.func_code == FUNC_CHAR && pick < 15) it.ch = CHAR_NEWLINE;
    else if (it.func_code == FUNC_CHAR && pick < 22) it.ch = CHAR_NUL;
    return it;
  endfunction

  // sender: offers queued items with random gaps
  item_t offered;
  int    send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        print_item(offered);
        accepted_items <= accepted_items + 1;
        if (offered.func_code == FUNC_HEX) n_hex++;
        else if (offered.ch == CHAR_NEWLINE || offered.ch == CHAR_NUL) n_quiet++;
        else n_print++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending.size() != 0) begin
          offered = pending.pop_front();
          func <= offered.func_code;
          character <= offered.ch;
          number <= offered.num;
          in_valid <= 1'b1;
          send_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off once, long enough to back up the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_items >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // receiver: checks each glyph transaction and stalls at random
  int stall_left = 0;

  always @(posedge clk) begin : receiver
    glyph_cmd_t want;
    int gap;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (glyph_queue.size() == 0) begin
          $display("%0t: unexpected glyph col %0d row %0d glyph %h last %b",
                   $time, glyph_column, glyph_row, glyph, last);
          errors++;
        end else begin
          want = glyph_queue.pop_front();
          checked++;
          if (glyph_column !== want.column) begin
            $display("%0t: glyph_column expected %0d actual %0d", $time, want.column,
                     glyph_column);
            errors++;
          end
          if (glyph_row !== want.row) begin
            $display("%0t: glyph_row expected %0d actual %0d", $time, want.row, glyph_row);
            errors++;
          end
          if (glyph !== want.glyph) begin
            $display("%0t: glyph expected %h actual %h", $time, want.glyph, glyph);
            errors++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (out_valid && out_ready) begin
        gap = gap_len();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left <= gap - 1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("text_console_cursor_hex_top verification failed");
      $finish;
    end
  end

  task automatic queue_item(input logic f, input logic [CHAR_W-1:0] ch,
                            input logic [NUM_W-1:0] num);
    pending.push_back('{f, ch, num});
  endtask

  task automatic fill_random(input int count, input int hex_pct);
    for (int i = 0; i < count; i++) pending.push_back(rand_item(hex_pct));
  endtask

  // both size registers, written while the block is idle
  task automatic set_screen(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rws);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data <= cols;
    @(posedge clk);
    columns_set = cols;
    cfg_index <= REG_ROWS;
    cfg_data <= rws;
    @(posedge clk);
    rows_set = rws;
    cfg_we <= 1'b0;
    settings++;
  endtask

  // wait for a quiet stretch with nothing offered or outstanding
  task automatic settle();
    int idle_run;
    idle_run = 0;
    while (idle_run < 8) begin
      @(posedge clk);
      if (pending.size() == 0 && !in_valid && glyph_queue.size() == 0) idle_run++;
      else idle_run = 0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed items on the reset screen
    queue_item(FUNC_CHAR, 8'h41, '1);                    // printable, number unused
    queue_item(FUNC_CHAR, CHAR_NUL, rand_number());      // skipped byte
    queue_item(FUNC_CHAR, CHAR_NEWLINE, rand_number());
    queue_item(FUNC_CHAR, 8'hFF, '0);
    queue_item(FUNC_CHAR, 8'h01, '0);
    queue_item(FUNC_HEX, 8'hFF, '0);                     // zero prints as 0x0
    queue_item(FUNC_HEX, 8'h00, 64'h1);
    queue_item(FUNC_HEX, 8'hA5, '1);                     // sixteen digits
    queue_item(FUNC_HEX, 8'h5A, 64'h8000_0000_0000_0000);
    queue_item(FUNC_HEX, 8'h00, 64'h0123_4567_89AB_CDEF);
    queue_item(FUNC_HEX, 8'h00, 64'hFEDC_BA98_7654_3210);
    queue_item(FUNC_CHAR, CHAR_NEWLINE, '0);
    queue_item(FUNC_CHAR, 8'h7E, '0);
    queue_item(FUNC_HEX, 8'h00, 64'hF0);
    settle();

    // tiny screen, cursor left outside it by the shrink
    set_screen(10'd3, 10'd2);
    queue_item(FUNC_HEX, 8'h00, '1);
    queue_item(FUNC_CHAR, CHAR_NEWLINE, '0);
    queue_item(FUNC_CHAR, 8'h5A, '0);
    queue_item(FUNC_HEX, 8'h00, '0);
    fill_random(70, 40);
    settle();

    // zero sizes act as one cell, no idling on either side
    set_screen(10'd0, 10'd0);
    calm <= 1'b1;
    fill_random(25, 30);
    settle();
    calm <= 1'b0;

    // oversized width clips at the cursor reach
    set_screen(10'd1023, 10'd3);
    fill_random(50, 95);
    settle();

    // one column, oversized height: row wraps at the reach
    set_screen(10'd1, 10'd1023);
    fill_random(50, 95);
    settle();

    set_screen(10'd513, 10'd512);
    fill_random(40, 50);
    settle();

    set_screen(COLUMNS_RESET, ROWS_RESET);
    fill_random(45, 40);
    settle();

    $display("run took %0d items: %0d hex, %0d printable, %0d newline or nul",
             n_hex + n_print + n_quiet, n_hex, n_print, n_quiet);
    $display("%0d glyph commands checked across %0d screen sizes, %0d mismatches",
             checked, settings, errors);
    if (errors == 0) begin
      $display("text_console_cursor_hex_top verification clean");
    end else begin
      $display("text_console_cursor_hex_top verification failed");
    end
    $finish;
  end

endmodule
